// ===== rtl/peer_exclusion_table_core_macros.svh =====
// Assertion macros shared by the peer exclusion table RTL.
`ifndef PEER_EXCLUSION_TABLE_CORE_MACROS_SVH
`define PEER_EXCLUSION_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PET_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PET_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pet_pkg.sv =====
// Shared constants, codes and types of the peer exclusion table.
`default_nettype none

package pet_pkg;

  // Default module parameters.
  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned SCORE_BITS_DEF  = 16;

  // Field widths.
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned TLIM_W      = 7;
  localparam int unsigned SLIM_W      = 8;
  localparam int unsigned PERIOD_W    = 20;
  localparam int unsigned OUT_SCORE_W = 16;
  localparam int unsigned OUT_CNT_W   = 7;

  // APB register port.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  // Request codes; the unused codes behave as a lookup.
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_TABLE_LIMIT    = 2'd0;
  localparam logic [1:0] REG_BAN_SCORE      = 2'd1;
  localparam logic [1:0] REG_EXCLUDE_PERIOD = 2'd2;

  // Register reset values.
  localparam logic [TLIM_W-1:0]   TABLE_LIMIT_RST    = 7'd64;
  localparam logic [SLIM_W-1:0]   BAN_SCORE_RST      = 8'd2;
  localparam logic [PERIOD_W-1:0] EXCLUDE_PERIOD_RST = 20'd3600;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Configuration handed from the register block to the controller.
  typedef struct packed {
    logic [TLIM_W-1:0]   table_limit;
    logic [SLIM_W-1:0]   ban_score;
    logic [PERIOD_W-1:0] exclude_period;
  } pet_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/pet_if.sv =====
// Request and response channel interfaces of the peer exclusion table.
`default_nettype none

interface pet_req_if;
  import pet_pkg::*;
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [ADDR_W-1:0]   addr_high;
  logic [ADDR_W-1:0]   addr_low;
  logic [TIME_W-1:0]   now_time;

  modport source (output valid, req_type, addr_high, addr_low, now_time, input ready);
  modport sink   (input valid, req_type, addr_high, addr_low, now_time, output ready);
endinterface

interface pet_rsp_if;
  import pet_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [OUT_SCORE_W-1:0] peer_score;
  logic [TIME_W-1:0]      deadline;
  logic                   excluded;
  logic [OUT_CNT_W-1:0]   entry_count;

  modport source (output valid, found, peer_score, deadline, excluded, entry_count,
                  input ready);
  modport sink   (input valid, found, peer_score, deadline, excluded, entry_count,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/pet_cfg_regs.sv =====
// APB configuration registers of the peer exclusion table.
`default_nettype none

module pet_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pet_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [pet_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [pet_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output pet_pkg::pet_cfg_t                    cfg_o
);
  import pet_pkg::*;

  logic [1:0] reg_idx;
  logic       wr_en;
  pet_cfg_t   cfg_q;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.table_limit    <= TABLE_LIMIT_RST;
      cfg_q.ban_score      <= BAN_SCORE_RST;
      cfg_q.exclude_period <= EXCLUDE_PERIOD_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TABLE_LIMIT:    cfg_q.table_limit    <= pwdata[TLIM_W-1:0];
        REG_BAN_SCORE:      cfg_q.ban_score      <= pwdata[SLIM_W-1:0];
        REG_EXCLUDE_PERIOD: cfg_q.exclude_period <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back decode.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TABLE_LIMIT:    prdata[TLIM_W-1:0]   = cfg_q.table_limit;
      REG_BAN_SCORE:      prdata[SLIM_W-1:0]   = cfg_q.ban_score;
      REG_EXCLUDE_PERIOD: prdata[PERIOD_W-1:0] = cfg_q.exclude_period;
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pet_table_mem.sv =====
// Single-port-write, registered-read memory holding the table entries.
`default_nettype none

module pet_table_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pet_ctrl.sv =====
// Sequencer that scans, evicts, updates and answers requests on the table.
`default_nettype none
`include "peer_exclusion_table_core_macros.svh"

module pet_ctrl #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned SCORE_BITS  = 16,
  parameter int unsigned ENT_W       = 1 + 2 * 64 + 16 + 48
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  pet_req_if.sink                             req,
  pet_rsp_if.source                           rsp,
  input  wire pet_pkg::pet_cfg_t              cfg_i,
  output logic                                mem_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]      mem_waddr_o,
  output logic [ENT_W-1:0]                    mem_wdata_o,
  output logic                                mem_re_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]      mem_raddr_o,
  input  wire logic [ENT_W-1:0]               mem_rdata_i
);
  import pet_pkg::*;

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PROD_W = PERIOD_W + SCORE_BITS;
  localparam int unsigned DLT_W  = PROD_W + 1;
  localparam int unsigned SUM_W  = ((DLT_W > TIME_W) ? DLT_W : TIME_W) + 1;
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0]      DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_SCAN   = 8'b0000_0100,
    ST_DECIDE = 8'b0000_1000,
    ST_EVICT  = 8'b0001_0000,
    ST_MULT   = 8'b0010_0000,
    ST_UPDATE = 8'b0100_0000,
    ST_RESP   = 8'b1000_0000
  } state_e;

  // Saturating add of a time and a duration.
  function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [DLT_W-1:0] d);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(d);
    if (s > SUM_W'(TIME_MAX)) begin
      return TIME_MAX;
    end
    return s[TIME_W-1:0];
  endfunction

  state_e state_q, state_d;

  // Request being served.
  logic [REQ_W-1:0]  req_q;
  logic [ADDR_W-1:0] hi_q, lo_q;
  logic [TIME_W-1:0] now_q;

  // Scan bookkeeping.
  logic [CNT_W-1:0]      iss_q;
  logic                  pend_q;
  logic [IDX_W-1:0]      chk_q;
  logic                  match_q;
  logic [IDX_W-1:0]      match_idx_q;
  logic [SCORE_BITS-1:0] hit_score_q;
  logic [TIME_W-1:0]     hit_dl_q;
  logic                  min_have_q;
  logic [IDX_W-1:0]      min_idx_q;
  logic [TIME_W-1:0]     min_dl_q;
  logic                  free_have_q;
  logic [IDX_W-1:0]      free_idx_q;
  logic [IDX_W-1:0]      clr_q;
  logic [CNT_W-1:0]      count_q;

  // Update datapath.
  logic [SCORE_BITS-1:0] score_new_q;
  logic [PROD_W-1:0]     prod_q;

  // Result and output stage.
  logic                   res_found_q;
  logic [SCORE_BITS-1:0]  res_score_q;
  logic [TIME_W-1:0]      res_dl_q;
  logic                   out_valid_q;
  logic                   out_found_q;
  logic [OUT_SCORE_W-1:0] out_score_q;
  logic [TIME_W-1:0]      out_dl_q;
  logic                   out_excl_q;
  logic [OUT_CNT_W-1:0]   out_cnt_q;

  logic                   accept;
  logic                   scan_done;
  logic                   evict_need;
  logic                   resp_load;
  logic                   rd_valid;
  logic [ADDR_W-1:0]      rd_hi, rd_lo;
  logic [SCORE_BITS-1:0]  rd_score;
  logic [TIME_W-1:0]      rd_dl;
  logic [SCORE_BITS-1:0]  score_inc;
  logic [TIME_W-1:0]      ins_dl, upd_dl;
  logic                   sc_eq, sc_gt, res_excl;
  logic [SCORE_BITS+OUT_SCORE_W-1:0] score_ext;
  logic [CNT_W+OUT_CNT_W-1:0]        cnt_ext;

  assign accept    = req.valid & req.ready;
  assign req.ready = (state_q == ST_IDLE);

  // Entry fields as read from the memory.
  assign rd_valid = mem_rdata_i[ENT_W-1];
  assign rd_hi    = mem_rdata_i[ENT_W-2 -: ADDR_W];
  assign rd_lo    = mem_rdata_i[ENT_W-2-ADDR_W -: ADDR_W];
  assign rd_score = mem_rdata_i[TIME_W +: SCORE_BITS];
  assign rd_dl    = mem_rdata_i[TIME_W-1:0];

  // One table read per cycle during a scan.
  assign mem_re_o    = (state_q == ST_SCAN) && (iss_q != DEPTH_CNT);
  assign mem_raddr_o = iss_q[IDX_W-1:0];
  assign scan_done   = (state_q == ST_SCAN) && pend_q && (chk_q == LAST_IDX);

  // Eviction is needed while the count is above one and at the effective limit.
  assign evict_need = (count_q > CNT_W'(1)) &&
                      (({{TLIM_W{1'b0}}, count_q} >= {{CNT_W{1'b0}}, cfg_i.table_limit}) ||
                       (count_q == DEPTH_CNT));

  // Score increment and deadline arithmetic.
  assign score_inc = (hit_score_q == SCORE_MAX) ? hit_score_q : hit_score_q + 1'b1;
  assign ins_dl    = sat_add(now_q, {{(DLT_W-PERIOD_W){1'b0}}, cfg_i.exclude_period});
  assign sc_eq     = {{SLIM_W{1'b0}}, score_new_q} == {{SCORE_BITS{1'b0}}, cfg_i.ban_score};
  assign sc_gt     = {{SLIM_W{1'b0}}, score_new_q} >  {{SCORE_BITS{1'b0}}, cfg_i.ban_score};
  assign upd_dl    = sc_gt ? sat_add(now_q, {prod_q, 1'b0}) : (sc_eq ? ins_dl : hit_dl_q);

  // Exclusion status of the finished result.
  assign res_excl  = ({{SLIM_W{1'b0}}, res_score_q} >= {{SCORE_BITS{1'b0}}, cfg_i.ban_score})
                     && (res_dl_q > now_q);
  assign score_ext = {{OUT_SCORE_W{1'b0}}, res_score_q};
  assign cnt_ext   = {{OUT_CNT_W{1'b0}}, count_q};
  assign resp_load = (state_q == ST_RESP) && (!out_valid_q || rsp.ready);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_q == LAST_IDX) state_d = ST_IDLE;
      ST_IDLE:   if (accept) state_d = ST_SCAN;
      ST_SCAN:   if (scan_done) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (req_q == REQ_ADD && match_q) begin
          state_d = ST_MULT;
        end else if (req_q == REQ_ADD && evict_need) begin
          state_d = ST_EVICT;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_EVICT:  state_d = ST_SCAN;
      ST_MULT:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_RESP;
      ST_RESP:   if (resp_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Table writes: clearing pass, eviction, insert, remove and score update.
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = clr_q;
    mem_wdata_o = '0;
    unique case (state_q)
      ST_CLEAR: mem_we_o = 1'b1;
      ST_EVICT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = min_idx_q;
      end
      ST_DECIDE: begin
        if (req_q == REQ_ADD && !match_q && !evict_need) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = free_idx_q;
          mem_wdata_o = {1'b1, hi_q, lo_q, SCORE_BITS'(1), ins_dl};
        end else if (req_q == REQ_REMOVE && match_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = match_idx_q;
        end
      end
      ST_UPDATE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = match_idx_q;
        mem_wdata_o = {1'b1, hi_q, lo_q, score_new_q, upd_dl};
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      match_q     <= 1'b0;
      min_have_q  <= 1'b0;
      free_have_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end

      // Scan start after an accepted beat or an eviction.
      if (accept || state_q == ST_EVICT) begin
        iss_q       <= '0;
        pend_q      <= 1'b0;
        match_q     <= 1'b0;
        min_have_q  <= 1'b0;
        free_have_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        pend_q <= mem_re_o;
        if (mem_re_o) begin
          iss_q <= iss_q + 1'b1;
        end
        if (pend_q) begin
          if (rd_valid && rd_hi == hi_q && rd_lo == lo_q) begin
            match_q <= 1'b1;
          end
          if (rd_valid && (!min_have_q || rd_dl < min_dl_q)) begin
            min_have_q <= 1'b1;
          end
          if (!rd_valid) begin
            free_have_q <= 1'b1;
          end
        end
      end

      // Entry count.
      if (state_q == ST_EVICT) begin
        count_q <= count_q - 1'b1;
      end else if (state_q == ST_DECIDE && mem_we_o) begin
        count_q <= (req_q == REQ_ADD) ? count_q + 1'b1 : count_q - 1'b1;
      end

      // Output register.
      if (resp_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req.req_type;
      hi_q  <= req.addr_high;
      lo_q  <= req.addr_low;
      now_q <= req.now_time;
    end
    chk_q <= mem_raddr_o;

    // Scan results per returned entry.
    if (state_q == ST_SCAN && pend_q) begin
      if (rd_valid && rd_hi == hi_q && rd_lo == lo_q) begin
        match_idx_q <= chk_q;
        hit_score_q <= rd_score;
        hit_dl_q    <= rd_dl;
      end
      if (rd_valid && (!min_have_q || rd_dl < min_dl_q)) begin
        min_idx_q <= chk_q;
        min_dl_q  <= rd_dl;
      end
      if (!rd_valid && !free_have_q) begin
        free_idx_q <= chk_q;
      end
    end

    // Score step and scaled period for a known address.
    if (state_q == ST_MULT) begin
      score_new_q <= score_inc;
      prod_q      <= {{SCORE_BITS{1'b0}}, cfg_i.exclude_period} *
                     {{PERIOD_W{1'b0}}, score_inc};
    end

    // Result fields.
    if (state_q == ST_DECIDE) begin
      res_found_q <= match_q;
      if (req_q == REQ_ADD) begin
        res_score_q <= SCORE_BITS'(1);
        res_dl_q    <= ins_dl;
      end else if (req_q == REQ_REMOVE || !match_q) begin
        res_score_q <= '0;
        res_dl_q    <= '0;
      end else begin
        res_score_q <= hit_score_q;
        res_dl_q    <= hit_dl_q;
      end
    end else if (state_q == ST_UPDATE) begin
      res_found_q <= 1'b1;
      res_score_q <= score_new_q;
      res_dl_q    <= upd_dl;
    end

    if (resp_load) begin
      out_found_q <= res_found_q;
      out_score_q <= score_ext[OUT_SCORE_W-1:0];
      out_dl_q    <= res_dl_q;
      out_excl_q  <= res_excl;
      out_cnt_q   <= cnt_ext[OUT_CNT_W-1:0];
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.found       = out_found_q;
  assign rsp.peer_score  = out_score_q;
  assign rsp.deadline    = out_dl_q;
  assign rsp.excluded    = out_excl_q;
  assign rsp.entry_count = out_cnt_q;

  // Checks on the sequencer.
  `PET_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= DEPTH_CNT, "count above depth")
  `PET_ASSERT_IMP(a_no_write_in_scan, clk_i, rst_ni, state_q == ST_SCAN, !mem_we_o, "write during scan")
  `PET_ASSERT_NXT(a_evict_dec, clk_i, rst_ni, state_q == ST_EVICT, count_q == $past(count_q) - 1'b1, "evict count")
  `PET_ASSERT_IMP(a_insert_free, clk_i, rst_ni, (state_q == ST_DECIDE) && (req_q == REQ_ADD) && !match_q && !evict_need, free_have_q, "no free slot")

endmodule

`default_nettype wire

// ===== rtl/peer_exclusion_table_core.sv =====
// Peer exclusion table: top level with register port, sequencer and entry memory.
//
// Usage: requests arrive on req_i (valid/ready); each beat carries a request
// type, a 128-bit peer address and the current time. Every request yields
// exactly one beat on rsp_o with found, score, deadline, excluded and the
// entry count. Limits and the exclusion period are to be written over the
// APB port only while the block is idle; the block itself does not enforce
// it; pready is always high.
// Scan: each request scans the whole table through the memory's single
// read port, one entry per cycle; an add on a known address then passes
// through a multiply and an update state, and every eviction rescans.
// One request is served at a time; req_i is ready only between requests.
// Reset: a clearing pass marks every entry free; req_i stays low-ready
// during it, register writes are taken as usual.
// Stall: the response waits in an output register; the next request may be
// accepted and processed meanwhile, and its result waits for that register.
`default_nettype none

module peer_exclusion_table_core #(
  parameter int unsigned TABLE_DEPTH = pet_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned SCORE_BITS  = pet_pkg::SCORE_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  pet_req_if.sink                             req_i,
  pet_rsp_if.source                           rsp_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pet_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [pet_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [pet_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);
  import pet_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned ENT_W = 1 + 2 * ADDR_W + SCORE_BITS + TIME_W;

  pet_cfg_t          cfg;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [ENT_W-1:0]  mem_rdata;

  pet_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pet_table_mem #(
    .DEPTH  (TABLE_DEPTH),
    .DATA_W (ENT_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pet_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SCORE_BITS  (SCORE_BITS),
    .ENT_W       (ENT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .rsp         (rsp_o),
    .cfg_i       (cfg),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

`default_nettype wire
